>>> design/hf_band_stack_memory_core_assert.svh
// Assertion macros for the band stack memory core.
`ifndef HF_BAND_STACK_MEMORY_CORE_ASSERT_SVH
`define HF_BAND_STACK_MEMORY_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define HBSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hf band stack memory core: assertion failed");

// Check cons in the cycle after ante.
`define HBSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hf band stack memory core: assertion failed");

`endif

>>> design/hbsm_pkg.sv
package hbsm_pkg;

  localparam int NUM_BANDS = 10;
  localparam int BAND_W    = 4;
  localparam int METERS_W  = 8;

  localparam logic [BAND_W-1:0] NO_BAND = BAND_W'(NUM_BANDS);

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  localparam logic [31:0] BAND_LOW [NUM_BANDS] = '{
    32'd27980000, 32'd24870000, 32'd20980000, 32'd18048000, 32'd13980000,
    32'd10080000, 32'd6980000,  32'd5310500,  32'd3480000,  32'd1780000
  };

  localparam logic [31:0] BAND_HIGH [NUM_BANDS] = '{
    32'd29710000, 32'd25000000, 32'd21460000, 32'd18170000, 32'd14360000,
    32'd10160000, 32'd7310000,  32'd5413500,  32'd4010000,  32'd2010000
  };

  localparam logic [METERS_W-1:0] BAND_METERS [NUM_BANDS] = '{
    8'd10, 8'd12, 8'd15, 8'd17, 8'd20, 8'd30, 8'd40, 8'd60, 8'd80, 8'd160
  };

endpackage

>>> design/hf_band_stack_memory_core.sv
// Band stack memory for ten HF amateur bands (160 m to 10 m).
// Input channel (in_valid/in_ready) carries one transaction of kind store,
// read or load. A store classifies in_freq_hz into a band and writes
// frequency and mode into that band's next ring slot, then advances the
// band's slot pointer. A read returns one stored slot; a load writes one
// slot without moving a pointer. Misses, bad addresses and unused kinds return band 10.
// Result channel (out_valid/out_ready) carries one transaction per input.
// Results are registered when the input is accepted. Throughput: one transaction
// per cycle while out_ready is high; the band compares, the slot memory access
// and the pointer update all complete in the cycle the input is accepted.
// The result register is the only stage: when the receiver stalls the
// result holds and in_ready stays high only if the result is taken in the
// same cycle, so at most one result waits.
// Reset (rst_n low at a clock edge) empties the result register, clears all
// slot valid bits so every slot reads as zero, and returns every slot
// pointer to slot 0. No clearing pass is needed.
module hf_band_stack_memory_core #(
  parameter int SLOTS     = 3,
  parameter int FREQ_BITS = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [FREQ_BITS-1:0] in_freq_hz,
  input  logic [7:0]           in_mode_code,
  input  logic [3:0]           in_band_sel,
  input  logic [1:0]           in_slot_sel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_band_code,
  output logic [FREQ_BITS-1:0] out_freq_out,
  output logic [7:0]           out_mode_out,
  output logic [7:0]           out_band_meters
);

  import hbsm_pkg::*;

  localparam int ENTRIES = NUM_BANDS * SLOTS;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int PTR_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [FREQ_BITS-1:0] freq_mem [ENTRIES];
  logic [7:0]           mode_mem [ENTRIES];
  logic [ENTRIES-1:0]   vld_r;
  logic [PTR_W-1:0]     ptr_r [NUM_BANDS];

  logic                 out_valid_r;
  logic [BAND_W-1:0]    band_r;
  logic [METERS_W-1:0]  meters_r;
  logic                 rd_hit_r;
  logic [FREQ_BITS-1:0] rd_freq_r;
  logic [7:0]           rd_mode_r;

  logic                 acc;
  logic [BAND_W-1:0]    hit_band;
  logic                 store_hit;
  logic                 sel_ok;
  logic [PTR_W-1:0]     st_ptr;
  logic [PTR_W-1:0]     ptr_nxt;
  logic [IDX_W-1:0]     st_idx;
  logic [IDX_W-1:0]     sel_idx;
  logic                 wr_en;
  logic                 rd_en;
  logic                 ptr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [BAND_W-1:0]    res_band;
  logic [METERS_W-1:0]  res_meters;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    hit_band = NO_BAND;
    for (int b = NUM_BANDS - 1; b >= 0; b--) begin
      if (32'(in_freq_hz) >= BAND_LOW[b] && 32'(in_freq_hz) <= BAND_HIGH[b]) begin
        hit_band = BAND_W'(b);
      end
    end
  end

  assign store_hit = (hit_band != NO_BAND);
  assign sel_ok    = (in_band_sel < NO_BAND) && (32'(in_slot_sel) < 32'(SLOTS));
  assign st_ptr    = store_hit ? ptr_r[hit_band] : '0;
  assign ptr_nxt   = (st_ptr >= PTR_W'(SLOTS - 1)) ? '0 : st_ptr + PTR_W'(1);
  assign st_idx    = IDX_W'(hit_band) * IDX_W'(SLOTS) + IDX_W'(st_ptr);
  assign sel_idx   = IDX_W'(in_band_sel) * IDX_W'(SLOTS) + IDX_W'(in_slot_sel);

  always_comb begin
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    ptr_en   = 1'b0;
    wr_idx   = sel_idx;
    res_band = NO_BAND;
    unique case (in_kind)
      KIND_STORE: begin
        if (store_hit) begin
          wr_en    = 1'b1;
          ptr_en   = 1'b1;
          wr_idx   = st_idx;
          res_band = hit_band;
        end
      end
      KIND_READ: begin
        if (sel_ok) begin
          rd_en    = 1'b1;
          res_band = in_band_sel;
        end
      end
      KIND_LOAD: begin
        if (sel_ok) begin
          wr_en    = 1'b1;
          res_band = in_band_sel;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_meters = (res_band < NO_BAND) ? BAND_METERS[res_band] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      ptr_r       <= '{default: '0};
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (acc && wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (acc && ptr_en) begin
        ptr_r[hit_band] <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      freq_mem[wr_idx] <= in_freq_hz;
      mode_mem[wr_idx] <= in_mode_code;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      band_r   <= res_band;
      meters_r <= res_meters;
      rd_hit_r <= rd_en && vld_r[sel_idx];
    end
    if (acc && rd_en) begin
      rd_freq_r <= freq_mem[sel_idx];
      rd_mode_r <= mode_mem[sel_idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_band_code   = band_r;
  assign out_band_meters = meters_r;
  assign out_freq_out    = rd_hit_r ? rd_freq_r : '0;
  assign out_mode_out    = rd_hit_r ? rd_mode_r : '0;

`include "hf_band_stack_memory_core_assert.svh"

  `HBSM_ASSERT_NOW(a_meters_no_band, out_valid && out_band_code == NO_BAND,
                   out_band_meters == '0)
  `HBSM_ASSERT_NOW(a_read_has_band, out_valid && rd_hit_r, out_band_code < NO_BAND)
  `HBSM_ASSERT_NOW(a_ptr_range, store_hit, st_ptr <= PTR_W'(SLOTS - 1))
  `HBSM_ASSERT_NEXT(a_store_band, acc && in_kind == KIND_STORE,
                    out_valid && out_band_code == $past(hit_band))

endmodule

>>> test/hf_band_stack_memory_core_tb.sv
module hf_band_stack_memory_core_tb;
  import hbsm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [3:0]  band;
    logic [25:0] freq;
    logic [7:0]  mode;
    logic [7:0]  meters;
  } band_result_t;

  class band_stack_scoreboard;
    int unsigned  lo_hz[10];
    int unsigned  hi_hz[10];
    logic [7:0]   meters[10];
    logic [25:0]  freq_mem[30];
    logic [7:0]   mode_mem[30];
    int unsigned  ring_ptr[10];
    logic [3:0]   tuned_band;
    band_result_t pending[$];
    int           errors;

    function new();
      lo_hz = '{27980000, 24870000, 20980000, 18048000, 13980000,
                10080000, 6980000, 5310500, 3480000, 1780000};
      hi_hz = '{29710000, 25000000, 21460000, 18170000, 14360000,
                10160000, 7310000, 5413500, 4010000, 2010000};
      meters = '{8'd10, 8'd12, 8'd15, 8'd17, 8'd20, 8'd30, 8'd40, 8'd60, 8'd80, 8'd160};
      foreach (freq_mem[i]) begin
        freq_mem[i] = '0;
        mode_mem[i] = '0;
      end
      foreach (ring_ptr[b]) ring_ptr[b] = 0;
      tuned_band = hbsm_pkg::NO_BAND;
      errors = 0;
    endfunction

    function logic [3:0] band_of(logic [25:0] f);
      for (int b = 0; b < 10; b++) begin
        if (f >= lo_hz[b] && f <= hi_hz[b]) return 4'(b);
      end
      return hbsm_pkg::NO_BAND;
    endfunction

    function void note_input(logic [1:0] kind, logic [25:0] f, logic [7:0] mode,
                             logic [3:0] band, logic [1:0] slot);
      band_result_t r;
      logic [3:0]   hit;
      int           idx;
      r = '0;
      r.band = hbsm_pkg::NO_BAND;
      case (kind) inside
        hbsm_pkg::KIND_STORE: begin
          hit = band_of(f);
          tuned_band = hit;
          if (hit != hbsm_pkg::NO_BAND) begin
            idx = hit * 3 + ring_ptr[hit];
            freq_mem[idx] = f;
            mode_mem[idx] = mode;
            ring_ptr[hit] = (ring_ptr[hit] >= 2) ? 0 : ring_ptr[hit] + 1;
            r.band = hit;
          end
        end
        hbsm_pkg::KIND_READ, hbsm_pkg::KIND_LOAD: begin
          if (band < 10 && slot < 3) begin
            idx = band * 3 + slot;
            r.band = band;
            if (kind == hbsm_pkg::KIND_READ) begin
              r.freq = freq_mem[idx];
              r.mode = mode_mem[idx];
            end else begin
              freq_mem[idx] = f;
              mode_mem[idx] = mode;
            end
          end
        end
        default: ;
      endcase
      if (r.band != hbsm_pkg::NO_BAND) r.meters = meters[r.band];
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(band_result_t got);
      band_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected transaction band_code", got.band, -1);
        return;
      end
      want = pending.pop_front();
      if (got.band != want.band) report_mismatch("band_code", got.band, want.band);
      if (got.freq != want.freq) report_mismatch("freq_out", got.freq, want.freq);
      if (got.mode != want.mode) report_mismatch("mode_out", got.mode, want.mode);
      if (got.meters != want.meters) report_mismatch("band_meters", got.meters, want.meters);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [25:0] in_freq_hz;
  logic [7:0]  in_mode_code;
  logic [3:0]  in_band_sel;
  logic [1:0]  in_slot_sel;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_band_code;
  logic [25:0] out_freq_out;
  logic [7:0]  out_mode_out;
  logic [7:0]  out_band_meters;

  band_stack_scoreboard sb = new();
  bit steady_flow = 1'b0;

  hf_band_stack_memory_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_freq_hz     (in_freq_hz),
    .in_mode_code   (in_mode_code),
    .in_band_sel    (in_band_sel),
    .in_slot_sel    (in_slot_sel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_band_code  (out_band_code),
    .out_freq_out   (out_freq_out),
    .out_mode_out   (out_mode_out),
    .out_band_meters(out_band_meters)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task send_item(input logic [1:0] kind, input logic [25:0] f, input logic [7:0] mode,
                 input logic [3:0] band, input logic [1:0] slot);
    if (!steady_flow && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_freq_hz   <= f;
    in_mode_code <= mode;
    in_band_sel  <= band;
    in_slot_sel  <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(kind, f, mode, band, slot);
  endtask

  task store_freq(input logic [25:0] f, input logic [7:0] mode);
    send_item(KIND_STORE, f, mode, 4'd0, 2'd0);
  endtask

  // Receiver: check every result, stall at random, one long hold-off.
  initial begin
    int cycles;
    int hold_left;
    out_ready <= 1'b0;
    cycles = 0;
    hold_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready)
        sb.check_result({out_band_code, out_freq_out, out_mode_out, out_band_meters});
      cycles++;
      if (cycles == 300) hold_left = 200;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady_flow) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 32);
      end
      @(posedge clk);
    end
  end

  initial begin
    int          pick;
    int          b;
    logic [25:0] f;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_kind      <= KIND_STORE;
    in_freq_hz   <= '0;
    in_mode_code <= '0;
    in_band_sel  <= '0;
    in_slot_sel  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    store_freq(26'd0, 8'h00);
    store_freq(26'h3FFFFFF, 8'hFF);
    store_freq(26'(sb.lo_hz[9] - 1), 8'h41);
    store_freq(26'(sb.hi_hz[0] + 1), 8'h42);
    for (int i = 0; i < 10; i++)
      store_freq(26'((i % 2 == 0) ? sb.lo_hz[i] : sb.hi_hz[i]), 8'(8'h30 + i));
    store_freq(26'(sb.hi_hz[9]), 8'hFF);
    send_item(KIND_READ, 26'h3FFFFFF, 8'hFF, 4'd9, 2'd0);
    send_item(KIND_READ, 26'd0, 8'h00, 4'd9, 2'd2);
    send_item(KIND_LOAD, 26'h3FFFFFF, 8'hFF, 4'd0, 2'd2);
    send_item(KIND_READ, 26'd0, 8'h00, 4'd0, 2'd2);
    send_item(KIND_LOAD, 26'd7100000, 8'h55, 4'd15, 2'd0);
    send_item(KIND_READ, 26'd0, 8'h00, 4'd3, 2'd3);
    send_item(KIND_UNUSED, 26'd14200000, 8'hAA, 4'd4, 2'd1);
    repeat (3) store_freq(26'd10100000, 8'h55);

    // Hold the sender until everything outstanding has drained.
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      steady_flow = (n >= 500 && n < 600);
      pick = $urandom_range(99);
      b = $urandom_range(9);
      case ($urandom_range(7))
        0: f = 26'(sb.lo_hz[b] - 1);
        1: f = 26'(sb.hi_hz[b] + 1);
        2: f = 26'(sb.lo_hz[b]);
        3: f = 26'(sb.hi_hz[b]);
        default: f = 26'($urandom_range(sb.hi_hz[b], sb.lo_hz[b]));
      endcase
      if (pick < 45)
        store_freq(f, 8'($urandom_range(255)));
      else if (pick < 70)
        send_item(KIND_READ, 26'($urandom()), 8'($urandom_range(255)),
                  4'($urandom_range(9)), 2'($urandom_range(2)));
      else if (pick < 82)
        send_item(KIND_LOAD, ($urandom_range(1) == 1) ? f : 26'($urandom()),
                  8'($urandom_range(255)), 4'(b), 2'($urandom_range(2)));
      else
        send_item(2'($urandom_range(3)), 26'($urandom()), 8'($urandom_range(255)),
                  4'($urandom_range(15)), 2'($urandom_range(3)));
    end
    steady_flow = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/hbsm_pkg.sv
design/hf_band_stack_memory_core.sv
test/hf_band_stack_memory_core_tb.sv
